### design/mesh_bbox_volume_centroid_macros.svh
// Assertion macros for the mesh bounding box, volume and centroid block.
`ifndef MESH_BBOX_VOLUME_CENTROID_MACROS_SVH
`define MESH_BBOX_VOLUME_CENTROID_MACROS_SVH
`ifndef SYNTHESIS
`define MBVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbvc: same-cycle check failed");
`define MBVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbvc: next-cycle check failed");
`else
`define MBVC_ASSERT_NOW(lbl, ante, cons)
`define MBVC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/mbvc_pkg.sv
// Shared widths, codes and controller/datapath interface types.
`default_nettype none
package mbvc_pkg;
  localparam int FIELD_BITS  = 12;
  localparam int VOL_BITS    = 47;
  localparam int WSUM_BITS   = 60;
  localparam int CEN_BITS    = 20;
  localparam int AXES        = 3;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 184;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       do_cof;
    logic       do_det;
    logic       do_acc;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       load_out;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic degen;
    logic sat;
  } sts_t;
endpackage
`default_nettype wire

### design/mbvc_datapath.sv
// Datapath: triple product, accumulators, bounding box, divider, result register.
`default_nettype none
module mbvc_datapath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [mbvc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tlast,
  input  wire mbvc_pkg::cmd_t                    cmd,
  output mbvc_pkg::sts_t                         sts,
  output logic [mbvc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tuser
);
  import mbvc_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int PROD_W = 2 * C;
  localparam int COF_W  = 2 * C + 1;
  localparam int TERM_W = 3 * C + 1;
  localparam int DET_W  = 3 * C + 3;
  localparam int SUM_W  = C + 2;
  localparam int WP_W   = SUM_W + DET_W;
  localparam int DEN_W  = VOL_BITS + 2;
  localparam int NUM_W  = WSUM_BITS + FRAC_BITS;
  localparam int CMP_W  = DEN_W + CEN_BITS;
  localparam logic signed [C-1:0] LOW_INIT  = C'((1 << (C - 1)) - 1);
  localparam logic signed [C-1:0] HIGH_INIT = C'(1 << (C - 1));
  localparam logic [CEN_BITS:0] LIM_NEG = (CEN_BITS+1)'(1) << (CEN_BITS - 1);
  localparam logic [CEN_BITS:0] LIM_POS = LIM_NEG - (CEN_BITS+1)'(1);

  // vertex coordinates, [vertex][axis]
  logic signed [C-1:0]         crd_r [3][3];
  logic                        last_r;
  logic signed [COF_W-1:0]     cof_r [3];
  logic signed [DET_W-1:0]     det_r;
  logic signed [C-1:0]         low_r [3];
  logic signed [C-1:0]         high_r [3];
  logic [VOL_BITS-1:0]         vol_r;
  logic [WSUM_BITS-1:0]        wsum_r [3];
  logic [DEN_W-1:0]            den_r, rem_r;
  logic [CEN_BITS-1:0]         lo_r, quo_r;
  logic                        neg_r, sat_r;
  logic [CEN_BITS-1:0]         cen_r [3];
  logic [OUT_TDATA_W-1:0]      out_data_r;
  logic                        out_user_r;

  logic signed [PROD_W-1:0]    p [6];
  logic signed [TERM_W-1:0]    t [3];
  logic signed [DET_W-1:0]     det_nxt;
  logic signed [SUM_W-1:0]     vsum [3];
  logic signed [WP_W-1:0]      wp [3];
  logic signed [C-1:0]         low_nxt [3];
  logic signed [C-1:0]         high_nxt [3];

  logic [WSUM_BITS-1:0]        w_sel, uw;
  logic [VOL_BITS-1:0]         uv;
  logic [DEN_W-1:0]            den;
  logic [NUM_W-1:0]            num;
  logic                        sat_c;
  logic [DEN_W:0]              trial;
  logic                        ge;
  logic                        rnd;
  logic [CEN_BITS:0]           qsum, limit, mag;
  logic [CEN_BITS-1:0]         cen_val;
  logic [OUT_TDATA_W-1:0]      out_pack;

  // cofactors of the triple product a . (b x c)
  assign p[0] = crd_r[1][1] * crd_r[2][2];
  assign p[1] = crd_r[2][1] * crd_r[1][2];
  assign p[2] = crd_r[0][1] * crd_r[2][2];
  assign p[3] = crd_r[2][1] * crd_r[0][2];
  assign p[4] = crd_r[0][1] * crd_r[1][2];
  assign p[5] = crd_r[1][1] * crd_r[0][2];

  assign t[0] = crd_r[0][0] * cof_r[0];
  assign t[1] = crd_r[1][0] * cof_r[1];
  assign t[2] = crd_r[2][0] * cof_r[2];
  assign det_nxt = DET_W'(t[0]) - DET_W'(t[1]) + DET_W'(t[2]);

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      vsum[ax] = SUM_W'(crd_r[0][ax]) + SUM_W'(crd_r[1][ax]) + SUM_W'(crd_r[2][ax]);
      wp[ax]   = vsum[ax] * det_r;
      low_nxt[ax]  = low_r[ax];
      high_nxt[ax] = high_r[ax];
      for (int v = 0; v < 3; v++) begin
        if (crd_r[v][ax] < low_nxt[ax]) low_nxt[ax] = crd_r[v][ax];
        if (crd_r[v][ax] > high_nxt[ax]) high_nxt[ax] = crd_r[v][ax];
      end
    end
  end

  // divider setup for the selected axis
  assign w_sel = wsum_r[cmd.axis];
  assign uw    = w_sel[WSUM_BITS-1] ? (~w_sel + WSUM_BITS'(1)) : w_sel;
  assign uv    = vol_r[VOL_BITS-1] ? (~vol_r + VOL_BITS'(1)) : vol_r;
  assign den   = {uv, 2'b00};
  assign num   = NUM_W'(uw) << FRAC_BITS;
  assign sat_c = CMP_W'(uw) >= (CMP_W'(den) << (CEN_BITS - FRAC_BITS));

  assign trial = {rem_r, lo_r[CEN_BITS-1]};
  assign ge    = trial >= {1'b0, den_r};

  assign rnd     = {rem_r, 1'b0} >= {1'b0, den_r};
  assign qsum    = {1'b0, quo_r} + (CEN_BITS+1)'(rnd);
  assign limit   = neg_r ? LIM_NEG : LIM_POS;
  assign mag     = (sat_r || (qsum > limit)) ? limit : qsum;
  assign cen_val = neg_r ? (~mag[CEN_BITS-1:0] + CEN_BITS'(1)) : mag[CEN_BITS-1:0];

  assign sts.last  = last_r;
  assign sts.degen = (vol_r == '0);
  assign sts.sat   = sat_c;

  always_comb begin
    out_pack = '0;
    for (int ax = 0; ax < 3; ax++) begin
      out_pack[ax*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(low_r[ax]);
      out_pack[(3+ax)*FIELD_BITS +: FIELD_BITS] =
        FIELD_BITS'(high_r[ax]) - FIELD_BITS'(low_r[ax]);
      out_pack[6*FIELD_BITS + VOL_BITS + ax*CEN_BITS +: CEN_BITS] =
        sts.degen ? '0 : cen_r[ax];
    end
    out_pack[6*FIELD_BITS +: VOL_BITS] = vol_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int v = 0; v < 3; v++) begin
        for (int ax = 0; ax < 3; ax++) begin
          crd_r[v][ax] <= in_tdata[(v*3+ax)*FIELD_BITS +: C];
        end
      end
      last_r <= in_tlast;
    end
    if (cmd.do_cof) begin
      cof_r[0] <= COF_W'(p[0]) - COF_W'(p[1]);
      cof_r[1] <= COF_W'(p[2]) - COF_W'(p[3]);
      cof_r[2] <= COF_W'(p[4]) - COF_W'(p[5]);
    end
    if (cmd.do_det) det_r <= det_nxt;
    if (cmd.div_init) begin
      den_r <= den;
      rem_r <= DEN_W'(num >> CEN_BITS);
      lo_r  <= num[CEN_BITS-1:0];
      neg_r <= w_sel[WSUM_BITS-1] ^ vol_r[VOL_BITS-1];
      sat_r <= sat_c;
    end else if (cmd.div_step) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      lo_r  <= {lo_r[CEN_BITS-2:0], 1'b0};
      quo_r <= {quo_r[CEN_BITS-2:0], ge};
    end
    if (cmd.div_fin) cen_r[cmd.axis] <= cen_val;
    if (cmd.load_out) begin
      out_data_r <= out_pack;
      out_user_r <= sts.degen;
    end
  end

  // accumulators: cleared by reset and after each result
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      vol_r <= '0;
      for (int ax = 0; ax < 3; ax++) begin
        low_r[ax]  <= LOW_INIT;
        high_r[ax] <= HIGH_INIT;
        wsum_r[ax] <= '0;
      end
    end else begin
      if (cmd.do_cof) begin
        for (int ax = 0; ax < 3; ax++) begin
          low_r[ax]  <= low_nxt[ax];
          high_r[ax] <= high_nxt[ax];
        end
      end
      if (cmd.do_acc) begin
        vol_r <= vol_r + VOL_BITS'(det_r);
        for (int ax = 0; ax < 3; ax++) begin
          wsum_r[ax] <= wsum_r[ax] + WSUM_BITS'(wp[ax]);
        end
      end
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule
`default_nettype wire

### design/mbvc_ctrl.sv
// Controller: sequences triangle arithmetic, centroid division and result handoff.
`default_nettype none
module mbvc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire mbvc_pkg::sts_t  sts,
  output mbvc_pkg::cmd_t       cmd
);
  import mbvc_pkg::*;

  localparam int ITER_W = $clog2(CEN_BITS);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COF  = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_LOAD = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              oval_r, oval_nxt;
  logic              can_load;

  assign can_load = !oval_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    iter_nxt  = iter_r;
    oval_nxt  = oval_r && !out_tready;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_COF;
        end
      end
      S_COF: begin
        cmd.do_cof = 1'b1;
        state_nxt  = S_DET;
      end
      S_DET: begin
        cmd.do_det = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.do_acc = 1'b1;
        axis_nxt   = AXIS_X;
        state_nxt  = sts.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (sts.degen) begin
          state_nxt = S_LOAD;
        end else begin
          cmd.div_init = 1'b1;
          iter_nxt     = '0;
          // skip the long division when the quotient is known to saturate
          state_nxt    = sts.sat ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(CEN_BITS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_LOAD;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_CHK;
        end
      end
      S_LOAD: begin
        if (can_load) begin
          cmd.load_out = 1'b1;
          oval_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AXIS_X;
      iter_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      iter_r  <= iter_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
endmodule
`default_nettype wire

### design/mesh_bbox_volume_centroid.sv
// Top level: triangle mesh bounding box, six times signed volume and centroid.
//
//  channel | dir | tdata            | tuser      | tlast
//  in_     | in  | 9 coords, 112 b  | -          | last triangle
//  out_    | out | box/vol/cen 184b | degenerate | -
//
// Each triangle passes accept, cofactors, triple product and accumulate in turn.
// On the last triangle the centroid divider runs per axis: a setup, 20 restoring
// steps (skipped when the quotient saturates) and a rounding step; then the
// result register loads once output is free. Degenerate meshes skip the divider.
// A waiting result does not block new triangles; only a second result stalls.
// Reset (rst_n low, synchronous) clears the box and the accumulators.
`default_nettype none
`include "mesh_bbox_volume_centroid_macros.svh"
module mesh_bbox_volume_centroid #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (12 b each), zero pad
  input  wire logic [mbvc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // min_x, min_y, min_z, extent_x, extent_y, extent_z (12 b each), six_volume (47 b),
  // centroid_x, centroid_y, centroid_z (20 b each), zero pad
  output logic [mbvc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // degenerate
  output logic                                   out_tuser
);
  import mbvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mbvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mbvc_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  `MBVC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `MBVC_ASSERT_NOW(a_valid_from_load, $rose(out_tvalid), $past(cmd.load_out))
  `MBVC_ASSERT_NOW(a_no_accept_in_div, cmd.div_step || cmd.div_fin, !in_tready)
endmodule
`default_nettype wire

### tb/sv/mesh_bbox_volume_centroid_chk.sv
// Checker: predicts mesh box, volume and centroid results and compares them.
module mesh_bbox_volume_centroid_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [mbvc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [mbvc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               out_tuser,
  output int                                 mismatches,
  output int                                 pending
);
  import mbvc_pkg::*;

  typedef struct packed {
    logic                 degen;
    logic [OUT_TDATA_W-1:0] bus;
  } mesh_summary_t;

  mesh_summary_t summary_q[$];

  logic signed [11:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [VOL_BITS-1:0]  vol_acc;
  logic [WSUM_BITS-1:0] wx_acc, wy_acc, wz_acc;

  task automatic clear_mesh();
    lo_x = 12'sd2047; lo_y = 12'sd2047; lo_z = 12'sd2047;
    hi_x = -12'sd2048; hi_y = -12'sd2048; hi_z = -12'sd2048;
    vol_acc = '0; wx_acc = '0; wy_acc = '0; wz_acc = '0;
  endtask

  // Round to nearest, ties away from zero, saturate to 20 bits.
  function automatic logic [CEN_BITS-1:0] centre_of(input longint w, input longint v);
    bit neg;
    longint unsigned uw, d, lim, q, r, rs, mag;
    neg = (w < 0) != (v < 0);
    uw = (w < 0) ? -w : w;
    d = 4 * ((v < 0) ? -v : v);
    lim = neg ? (64'd1 << (CEN_BITS - 1)) : ((64'd1 << (CEN_BITS - 1)) - 1);
    q = uw / d;
    r = uw % d;
    if (q > (lim >> 8)) begin
      mag = lim;
    end else begin
      rs = r << 8;
      mag = (q << 8) + rs / d + ((2 * (rs % d) >= d) ? 1 : 0);
      if (mag > lim) mag = lim;
    end
    return neg ? CEN_BITS'(-mag) : CEN_BITS'(mag);
  endfunction

  task automatic add_triangle(input logic [IN_TDATA_W-1:0] d, input logic fin);
    longint p[9];
    longint det, vs, wx, wy, wz;
    mesh_summary_t s;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(d[12*i +: 12]));
    // vertex i holds x, y, z in slots 3i, 3i+1, 3i+2
    for (int i = 0; i < 3; i++) begin
      if (p[3*i] < lo_x) lo_x = 12'(p[3*i]);
      if (p[3*i] > hi_x) hi_x = 12'(p[3*i]);
      if (p[3*i+1] < lo_y) lo_y = 12'(p[3*i+1]);
      if (p[3*i+1] > hi_y) hi_y = 12'(p[3*i+1]);
      if (p[3*i+2] < lo_z) lo_z = 12'(p[3*i+2]);
      if (p[3*i+2] > hi_z) hi_z = 12'(p[3*i+2]);
    end
    // field order is a_x a_y a_z b_x ...; regroup per axis
    begin
      longint ax, ay, az, bx, by, bz, cx, cy, cz;
      ax = p[0]; ay = p[1]; az = p[2]; bx = p[3]; by = p[4]; bz = p[5];
      cx = p[6]; cy = p[7]; cz = p[8];
      det = ax * (by * cz - cy * bz) - bx * (ay * cz - cy * az) + cx * (ay * bz - by * az);
      vol_acc += VOL_BITS'(det);
      wx_acc += WSUM_BITS'((ax + bx + cx) * det);
      wy_acc += WSUM_BITS'((ay + by + cy) * det);
      wz_acc += WSUM_BITS'((az + bz + cz) * det);
    end
    if (!fin) return;
    vs = longint'($signed(vol_acc));
    wx = longint'($signed(wx_acc));
    wy = longint'($signed(wy_acc));
    wz = longint'($signed(wz_acc));
    s = '0;
    s.bus[11:0] = lo_x; s.bus[23:12] = lo_y; s.bus[35:24] = lo_z;
    s.bus[47:36] = hi_x - lo_x; s.bus[59:48] = hi_y - lo_y; s.bus[71:60] = hi_z - lo_z;
    s.bus[118:72] = vol_acc;
    s.degen = (vs == 0);
    if (vs != 0) begin
      s.bus[138:119] = centre_of(wx, vs);
      s.bus[158:139] = centre_of(wy, vs);
      s.bus[178:159] = centre_of(wz, vs);
    end
    summary_q.push_back(s);
    clear_mesh();
  endtask

  initial begin
    mismatches = 0;
    clear_mesh();
  end

  assign pending = summary_q.size();

  always @(posedge clk) begin
    mesh_summary_t want;
    if (rst_n && in_tvalid && in_tready) add_triangle(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", out_tdata);
      end else begin
        want = summary_q.pop_front();
        if (want.bus !== out_tdata || want.degen !== out_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h/%b actual %h/%b",
                     want.bus, want.degen, out_tdata, out_tuser);
        end
      end
    end
  end
endmodule

### tb/sv/mesh_bbox_volume_centroid_tb.sv
// Testbench top: drives triangle meshes, stalls the result side, gives the verdict.
module mesh_bbox_volume_centroid_tb;
  import mbvc_pkg::*;

  logic clk, rst_n;
  logic in_tvalid, in_tlast, out_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tready, out_tvalid, out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int mismatches, pending;
  int send_idle_pct, recv_idle_pct, hold_cycles;

  mesh_bbox_volume_centroid dut (.*);
  mesh_bbox_volume_centroid_chk chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stalls, plus a long hold when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [11:0] pick_coord(input int mode);
    case (mode)
      0: return 12'h800;
      1: return 12'h7ff;
      2: return 12'($signed($urandom_range(40)) - 20);
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_tri(input logic [IN_TDATA_W-1:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_mesh(input int count, input int mode);
    logic [IN_TDATA_W-1:0] d;
    for (int t = 0; t < count; t++) begin
      d = '0;
      for (int i = 0; i < 9; i++) d[12*i +: 12] = pick_coord(mode < 0 ? $urandom_range(3) : mode);
      send_tri(d, t == count - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [IN_TDATA_W-1:0] d;
    rst_n = 0; in_tvalid = 0; in_tlast = 0; in_tdata = '0;
    hold_cycles = 0; send_idle_pct = 0; recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flat mesh (degenerate), all-min, all-max, unit tetrahedron
    send_tri('0, 1'b1);
    d = '0; for (int i = 0; i < 9; i++) d[12*i +: 12] = 12'h800;
    send_tri(d, 1'b1);
    d = '0; for (int i = 0; i < 9; i++) d[12*i +: 12] = 12'h7ff;
    send_tri(d, 1'b1);
    d = '0; d[11:0] = 12'h7ff; d[59:48] = 12'h7ff; d[107:96] = 12'h7ff;
    send_tri(d, 1'b1);
    d[11:0] = 12'h800; d[59:48] = 12'h800; d[107:96] = 12'h800;
    send_tri(d, 1'b1);
    d[11:0] = 12'h800; d[59:48] = 12'h7ff; d[107:96] = 12'h7ff;
    send_tri(d, 1'b0);
    d[11:0] = 12'h7ff; d[59:48] = 12'h800; d[107:96] = 12'h001;
    send_tri(d, 1'b1);
    d = '0; d[11:0] = 12'd1; d[59:48] = 12'd1; d[107:96] = 12'd1;
    send_tri(d, 1'b1);
    send_mesh(4, 0);
    send_mesh(4, 1);
    send_mesh(3, 2);
    // pause until everything is back
    drain();

    // long receiver hold while triangles keep coming
    hold_cycles <= 300;
    send_mesh(3, 3); send_mesh(3, 3); send_mesh(3, 3); send_mesh(3, 3);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 6 : 0;
      for (int done = 0; done < 240; ) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 6);
        send_mesh(n, -1);
        done += n;
      end
      drain();
    end

    in_tvalid <= 1'b0;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/mbvc_pkg.sv
design/mbvc_datapath.sv
design/mbvc_ctrl.sv
design/mesh_bbox_volume_centroid.sv
tb/sv/mesh_bbox_volume_centroid_chk.sv
tb/sv/mesh_bbox_volume_centroid_tb.sv
